### rtl/rtmf_pkg.sv
// Shared types and constants for the terminated message receive framer.
// Used by rtmf_ctrl, rtmf_datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none
package rtmf_pkg;
    localparam int BUFFER_BYTES = 128;
    localparam int SLOT_COUNT   = 8;
    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int SW = $clog2(SLOT_COUNT);

    typedef enum logic [1:0] {
        CMD_BYTE  = 2'd0,
        CMD_FETCH = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    localparam logic [1:0] MODE_IDLE     = 2'd0;
    localparam logic [1:0] MODE_ACTIVE   = 2'd1;
    localparam logic [1:0] MODE_DROPPING = 2'd2;

    localparam logic [0:0] REG_TERM_VALUE = 1'b0;
    localparam logic [0:0] REG_TERM_RUN   = 1'b1;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  rx_byte;
        logic [31:0] arrival_time;
        logic [6:0]  read_address;
    } t_in_word;

    typedef struct packed {
        logic [6:0]  message_length;
        logic [6:0]  message_start;
        logic [31:0] message_timestamp;
        logic [7:0]  read_data;
        logic        message_done;
        logic [1:0]  receive_status;
    } t_out_word;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture input word
        logic exec;     // perform the update
        logic finish;   // build result word
    } t_cmd_bus;
endpackage
`default_nettype wire

### rtl/rx_terminated_message_framer.sv
// Receive framer top level: APB registers, controller and datapath.
// The sequencer handles one word at a time, stepping through the load, memory read, execute
// and output steps; it takes a new word only when idle and no pending result is stalled.
// Reset (synchronous, active low) empties the descriptor ring and idles the receiver;
// the byte store is not cleared. Terminator value resets to 0xFF, run to 3.
`timescale 1ns / 1ps
`default_nettype none
module rx_terminated_message_framer (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  rtmf_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output rtmf_pkg::t_out_word o_out_data,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire [2:0]           paddr,
    input  wire [31:0]          pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import rtmf_pkg::*;
    logic [7:0] r_term_value;
    logic [1:0] r_term_run;
    t_cmd_bus   w_cmd;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_value <= 8'hFF;
            r_term_run   <= 2'd3;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            unique case (paddr[2])
                REG_TERM_VALUE: r_term_value <= pwdata[7:0];
                REG_TERM_RUN:   r_term_run   <= pwdata[1:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        prdata = '0;
        if (paddr == 3'd0) prdata = {24'd0, r_term_value};
        else if (paddr == 3'd4) prdata = {30'd0, r_term_run};
    end

    rtmf_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall), .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall), .o_cmd(w_cmd)
    );
    rtmf_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_word(i_in_data),
        .i_term_value(r_term_value), .i_term_run(r_term_run), .o_word(o_out_data)
    );

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |=> !w_cmd.load) else $error("accept while busy");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.receive_status != 2'd3) else $error("bad status");
    a_done_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.message_done |-> o_out_data.message_length == 7'd0)
        else $error("done with fetch fields");
`endif
endmodule
`default_nettype wire

### rtl/rtmf_ctrl.sv
// Sequencer for the framer: load, read memories, execute, present result.
// Depends on rtmf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rtmf_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  wire              i_out_stall,
    output rtmf_pkg::t_cmd_bus o_cmd
);
    import rtmf_pkg::*;
    typedef enum logic [1:0] {S_IDLE, S_FETCH, S_EXEC, S_OUT} t_state;
    t_state r_state;
    logic   r_valid;

    assign o_in_stall  = (r_state != S_IDLE) || (r_valid && i_out_stall);
    assign o_out_valid = r_valid;
    assign o_cmd.load   = (r_state == S_IDLE) && i_in_valid && !o_in_stall;
    assign o_cmd.exec   = (r_state == S_EXEC);
    assign o_cmd.finish = (r_state == S_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && !i_out_stall) r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE:  if (o_cmd.load) r_state <= S_FETCH;
                S_FETCH: r_state <= S_EXEC;
                S_EXEC:  r_state <= S_OUT;
                S_OUT: begin
                    r_state <= S_IDLE;
                    r_valid <= 1'b1;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### rtl/rtmf_datapath.sv
// Byte store, descriptor ring and framing registers of the framer.
// Depends on rtmf_pkg; driven by rtmf_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none
module rtmf_datapath (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  rtmf_pkg::t_cmd_bus  i_cmd,
    input  rtmf_pkg::t_in_word  i_word,
    input  wire [7:0]           i_term_value,
    input  wire [1:0]           i_term_run,
    output rtmf_pkg::t_out_word o_word
);
    import rtmf_pkg::*;

    logic [7:0]    r_store [BUFFER_BYTES];
    logic [AW-1:0] r_slot_start [SLOT_COUNT];
    logic [AW-1:0] r_slot_len   [SLOT_COUNT];
    logic [31:0]   r_slot_time  [SLOT_COUNT];
    logic [SW-1:0] r_push, r_pop, r_held;
    logic          r_held_v;
    logic [AW:0]   r_cursor, r_limit;
    logic [AW-1:0] r_begin;
    logic [1:0]    r_run_cnt, r_mode;
    t_in_word      r_in;
    logic [7:0]    r_rd;
    logic          r_done;
    t_out_word     r_out;
    logic [AW-1:0] r_o_len, r_o_start;
    logic [31:0]   r_o_time;

    function automatic logic [SW-1:0] nxt(input logic [SW-1:0] i);
        nxt = (i == SW'(SLOT_COUNT - 1)) ? '0 : i + 1'b1;
    endfunction

    // byte path combinational work
    logic [SW-1:0] w_ns;
    logic          w_have, w_open;
    logic [AW:0]   w_rdp, w_begin, w_limit, w_cur0, w_cur1, w_framed, w_pay;
    logic [1:0]    w_run, w_cnt, w_mode0, w_mode1;
    logic          w_wr, w_match;

    always_comb begin
        w_ns   = nxt(r_push);
        w_have = 1'b0;
        w_rdp  = '0;
        if (r_held_v) begin
            w_rdp = {1'b0, r_slot_start[r_held]}; w_have = 1'b1;
        end else if (r_slot_len[r_pop] != '0) begin
            w_rdp = {1'b0, r_slot_start[r_pop]}; w_have = 1'b1;
        end
        w_begin = '0;
        w_limit = '0;
        w_cur0  = r_cursor;
        if (!w_have) begin
            w_limit = (AW+1)'(BUFFER_BYTES);
        end else if (r_cursor >= w_rdp) begin
            if ((AW+1)'(BUFFER_BYTES) - r_cursor >= w_rdp) begin
                w_begin = r_cursor; w_limit = (AW+1)'(BUFFER_BYTES);
            end else begin
                w_limit = w_rdp;
            end
        end else begin
            w_begin = r_cursor; w_limit = w_rdp;
        end
        w_open = (r_slot_len[w_ns] == '0) && (w_begin != w_limit);
        if (!w_have) w_open = (r_slot_len[w_ns] == '0);

        w_mode0 = r_mode;
        if (r_mode == MODE_IDLE) begin
            w_mode0 = w_open ? MODE_ACTIVE : MODE_DROPPING;
            if (w_open) w_cur0 = w_begin;
            else        w_cur0 = r_cursor;
        end
        w_wr   = 1'b0;
        w_cur1 = w_cur0;
        w_mode1 = w_mode0;
        if (w_mode0 == MODE_ACTIVE) begin
            if (w_cur0 < ((r_mode == MODE_IDLE) ? w_limit : r_limit)
                && w_cur0 < (AW+1)'(BUFFER_BYTES)) begin
                w_wr = 1'b1; w_cur1 = w_cur0 + 1'b1;
            end else begin
                w_mode1 = MODE_DROPPING;
            end
        end
        w_run = (i_term_run == 2'd0) ? 2'd1 : i_term_run;
        w_cnt = r_run_cnt;
        if (r_in.rx_byte == i_term_value) begin
            if (r_run_cnt < w_run) w_cnt = r_run_cnt + 1'b1;
        end else begin
            w_cnt = '0;
        end
        w_match  = (w_cnt == w_run);
        w_framed = w_cur1 - ((r_mode == MODE_IDLE && w_open) ?
                             w_begin : {1'b0, r_begin});
        w_pay    = (w_framed >= {{(AW-1){1'b0}}, w_run}) ?
                   w_framed - {{(AW-1){1'b0}}, w_run} : '0;
    end

    logic [AW-1:0] w_beg_eff;
    logic [AW:0]   w_lim_eff;
    assign w_beg_eff = (r_mode == MODE_IDLE && w_open) ? w_begin[AW-1:0] : r_begin;
    assign w_lim_eff = (r_mode == MODE_IDLE) ? (w_open ? w_limit : r_limit) : r_limit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_in <= i_word;
        r_rd <= r_store[r_in.read_address];
        if (i_cmd.exec && r_in.command == CMD_BYTE && w_wr)
            r_store[w_cur0[AW-1:0]] <= r_in.rx_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SLOT_COUNT; k++) begin
                r_slot_start[k] <= '0;
                r_slot_len[k]   <= '0;
                r_slot_time[k]  <= '0;
            end
            r_push <= SW'(SLOT_COUNT - 1);
            r_pop <= '0; r_held <= '0; r_held_v <= 1'b0;
            r_cursor <= '0; r_limit <= '0; r_begin <= '0;
            r_run_cnt <= '0; r_mode <= MODE_IDLE;
            r_done <= 1'b0; r_o_len <= '0; r_o_start <= '0; r_o_time <= '0;
        end else if (i_cmd.exec) begin
            r_done <= 1'b0; r_o_len <= '0; r_o_start <= '0; r_o_time <= '0;
            case (r_in.command)
                CMD_BYTE: begin
                    r_cursor  <= w_cur1;
                    r_mode    <= w_mode1;
                    r_run_cnt <= w_cnt;
                    r_begin   <= w_beg_eff;
                    r_limit   <= w_lim_eff;
                    if (w_match) begin
                        if (w_mode1 == MODE_ACTIVE) begin
                            r_cursor <= {1'b0, w_beg_eff} + w_pay;
                            if (w_pay != '0) begin
                                r_slot_start[w_ns] <= w_beg_eff;
                                r_slot_time[w_ns]  <= r_in.arrival_time;
                                r_slot_len[w_ns]   <= w_pay[AW-1:0];
                                r_push <= w_ns;
                                r_done <= 1'b1;
                            end
                        end else if (w_lim_eff != '0) begin
                            r_cursor <= {1'b0, w_beg_eff};
                        end
                        r_limit <= '0; r_run_cnt <= '0; r_mode <= MODE_IDLE;
                    end
                end
                CMD_FETCH: begin
                    if (r_held_v) begin
                        r_slot_len[r_held] <= '0;
                        r_held_v <= 1'b0;
                    end
                    if (r_slot_len[r_pop] != '0 && !(r_held_v && r_held == r_pop)) begin
                        r_o_len   <= r_slot_len[r_pop];
                        r_o_start <= r_slot_start[r_pop];
                        r_o_time  <= r_slot_time[r_pop];
                        r_held    <= r_pop; r_held_v <= 1'b1;
                        r_pop     <= nxt(r_pop);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.message_length    <= r_o_len;
            r_out.message_start     <= r_o_start;
            r_out.message_timestamp <= r_o_time;
            r_out.read_data <= (r_in.command == CMD_READ) ? r_rd : 8'd0;
            r_out.message_done      <= r_done;
            r_out.receive_status    <= r_mode;
        end
    end
    assign o_word = r_out;
endmodule
`default_nettype wire

### verif/rx_terminated_message_framer_tb.sv
// Self-checking testbench for rx_terminated_message_framer: drives framed byte streams,
// fetches and store reads, predicts every result word, and checks it field by field.
// Depends on rtmf_pkg and the rx_terminated_message_framer RTL.
`timescale 1ns / 1ps
module rx_terminated_message_framer_tb;
    import rtmf_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_word    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_word   o_out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    rx_terminated_message_framer u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial forever #5 i_clk = ~i_clk;

    t_in_word  words_to_send[$];
    t_out_word results_due[$];
    int        send_idle_pct = 0;
    int        stall_pct = 0;
    bit        hold_go = 0;
    bit        hold_done = 0;
    int        hold_cnt = 0;
    int        errors = 0;
    int        quiet_cycles = 0;

    // framer state mirror
    logic [7:0]  term_value = 8'hFF;
    logic [1:0]  term_run = 2'd3;
    logic [7:0]  store [BUFFER_BYTES];
    bit          written [BUFFER_BYTES];
    int          ring_start [SLOT_COUNT];
    int          ring_len [SLOT_COUNT];
    logic [31:0] ring_time [SLOT_COUNT];
    int push_idx = SLOT_COUNT - 1, pop_idx = 0, held_idx = SLOT_COUNT;
    int cursor = 0, frame_base = 0, frame_end = 0, run_seen = 0;
    logic [1:0] rx_state = MODE_IDLE;

    function automatic int slot_after(int i);
        return (i >= SLOT_COUNT - 1) ? 0 : i + 1;
    endfunction

    function automatic bit claim_region();
        int nxt, rd, base, lim;
        bit have;
        nxt = slot_after(push_idx);
        have = 0; rd = 0; base = 0; lim = 0;
        if (ring_len[nxt] != 0) return 0;
        if (held_idx < SLOT_COUNT) begin
            rd = ring_start[held_idx]; have = 1;
        end else if (ring_len[pop_idx] != 0) begin
            rd = ring_start[pop_idx]; have = 1;
        end
        if (!have) begin
            cursor = 0; lim = BUFFER_BYTES;
        end else if (cursor >= rd) begin
            if (BUFFER_BYTES - cursor >= rd) begin
                base = cursor; lim = BUFFER_BYTES;
            end else begin
                lim = rd;
            end
        end else begin
            base = cursor; lim = rd;
        end
        if (base == lim) return 0;
        frame_base = base; cursor = base; frame_end = lim;
        return 1;
    endfunction

    function automatic bit accept_byte(logic [7:0] b, logic [31:0] stamp);
        int run, framed, payload, s;
        bit done;
        run = (term_run == 0) ? 1 : term_run;
        done = 0;
        if (rx_state == MODE_IDLE) rx_state = claim_region() ? MODE_ACTIVE : MODE_DROPPING;
        if (rx_state == MODE_ACTIVE) begin
            if (cursor < frame_end && cursor < BUFFER_BYTES) begin
                store[cursor] = b; written[cursor] = 1; cursor++;
            end else begin
                rx_state = MODE_DROPPING;
            end
        end
        if (b == term_value) begin
            if (run_seen < run) run_seen++;
        end else begin
            run_seen = 0;
        end
        if (run_seen == run) begin
            if (rx_state == MODE_ACTIVE) begin
                framed = cursor - frame_base;
                payload = (framed >= run) ? framed - run : 0;
                cursor = frame_base + payload;
                if (payload > 0) begin
                    s = slot_after(push_idx);
                    ring_start[s] = frame_base; ring_time[s] = stamp;
                    ring_len[s] = payload; push_idx = s; done = 1;
                end
            end else if (frame_end != 0) begin
                cursor = frame_base;
            end
            frame_end = 0; run_seen = 0; rx_state = MODE_IDLE;
        end
        return done;
    endfunction

    function automatic t_out_word frame_result(t_in_word w);
        t_out_word r;
        r = '0;
        case (t_cmd'(w.command))
            CMD_BYTE: r.message_done = accept_byte(w.rx_byte, w.arrival_time);
            CMD_FETCH: begin
                if (held_idx < SLOT_COUNT) begin
                    ring_len[held_idx] = 0; held_idx = SLOT_COUNT;
                end
                if (ring_len[pop_idx] != 0) begin
                    r.message_length = 7'(ring_len[pop_idx]);
                    r.message_start = 7'(ring_start[pop_idx]);
                    r.message_timestamp = ring_time[pop_idx];
                    held_idx = pop_idx; pop_idx = slot_after(pop_idx);
                end
            end
            CMD_READ: r.read_data = store[w.read_address];
            default: ;
        endcase
        r.receive_status = rx_state;
        return r;
    endfunction

    task automatic queue_word(t_cmd cmd, logic [7:0] b, logic [31:0] stamp, logic [6:0] addr);
        t_in_word w;
        w.command = cmd; w.rx_byte = b; w.arrival_time = stamp; w.read_address = addr;
        results_due.push_back(frame_result(w));
        words_to_send.push_back(w);
    endtask

    task automatic queue_message(int n);
        logic [7:0] b;
        int run;
        run = (term_run == 0) ? 1 : term_run;
        for (int k = 0; k < n; k++) begin
            b = 8'($urandom_range(0, 255));
            if (b == term_value && $urandom_range(0, 3) != 0) b = b ^ 8'h01;
            queue_word(CMD_BYTE, b, $urandom, 7'($urandom));
        end
        for (int k = 0; k < run; k++) queue_word(CMD_BYTE, term_value, $urandom, 7'($urandom));
    endtask

    task automatic queue_read();
        logic [6:0] a;
        for (int k = 0; k < 16; k++) begin
            a = 7'($urandom);
            if (written[a]) begin
                queue_word(CMD_READ, 8'($urandom), $urandom, a);
                return;
            end
        end
    endtask

    task automatic queue_random(int n);
        int pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) queue_message(($urandom_range(0, 15) == 0) ?
                                         $urandom_range(20, 130) : $urandom_range(0, 12));
            else if (pick < 75) queue_word(CMD_FETCH, 8'($urandom), $urandom, 7'($urandom));
            else if (pick < 88) queue_read();
            else if (pick < 93) queue_word(CMD_NONE, 8'($urandom), $urandom, 7'($urandom));
            else queue_word(CMD_BYTE, 8'($urandom), $urandom, 7'($urandom));
        end
    endtask

    task automatic wait_drained();
        wait (words_to_send.size() == 0 && results_due.size() == 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == {REG_TERM_RUN, 2'b00}) term_run = data[1:0];
        else term_value = data[7:0];
    endtask

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || !o_in_stall) begin
                if (words_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= words_to_send.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        if (hold_go && !hold_done) begin
            i_out_stall <= 1'b1;
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == LONG_HOLD) hold_done <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_word want;
        if (o_out_valid && !i_out_stall) begin
            if (results_due.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                want = results_due.pop_front();
                if (o_out_data.message_length !== want.message_length) begin
                    $error("message_length exp %0d got %0d", want.message_length,
                           o_out_data.message_length); errors++;
                end
                if (o_out_data.message_start !== want.message_start) begin
                    $error("message_start exp %0d got %0d", want.message_start,
                           o_out_data.message_start); errors++;
                end
                if (o_out_data.message_timestamp !== want.message_timestamp) begin
                    $error("message_timestamp exp %0h got %0h", want.message_timestamp,
                           o_out_data.message_timestamp); errors++;
                end
                if (o_out_data.read_data !== want.read_data) begin
                    $error("read_data exp %0h got %0h", want.read_data,
                           o_out_data.read_data); errors++;
                end
                if (o_out_data.message_done !== want.message_done) begin
                    $error("message_done exp %0d got %0d", want.message_done,
                           o_out_data.message_done); errors++;
                end
                if (o_out_data.receive_status !== want.receive_status) begin
                    $error("receive_status exp %0d got %0d", want.receive_status,
                           o_out_data.receive_status); errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (words_to_send.size() == 0 && results_due.size() == 0)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0] vals [5];
        logic [1:0] runs [5];
        vals = '{8'hFF, 8'h0D, 8'h00, 8'hFF, 8'h5A};
        runs = '{2'd3, 2'd1, 2'd2, 2'd0, 2'd3};
        for (int i = 0; i < BUFFER_BYTES; i++) written[i] = 0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            ring_start[i] = 0; ring_len[i] = 0; ring_time[i] = '0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset defaults, empty fetch, idle command, extremes
        queue_word(CMD_FETCH, 8'h00, 32'h0, 7'h00);
        queue_word(CMD_NONE, 8'hFF, 32'hFFFF_FFFF, 7'h7F);
        queue_word(CMD_BYTE, 8'hFF, 32'h0, 7'h00);
        queue_word(CMD_BYTE, 8'hFF, 32'h0, 7'h00);
        queue_word(CMD_BYTE, 8'hFF, 32'h0, 7'h00);
        queue_word(CMD_BYTE, 8'h00, 32'h0, 7'h00);
        queue_word(CMD_BYTE, 8'hFF, 32'h1, 7'h00);
        queue_word(CMD_BYTE, 8'hFF, 32'h2, 7'h00);
        queue_word(CMD_BYTE, 8'hFF, 32'hFFFF_FFFF, 7'h00);
        queue_word(CMD_FETCH, 8'h00, 32'h0, 7'h00);
        queue_word(CMD_READ, 8'h00, 32'h0, 7'h00);
        queue_message(130);
        queue_word(CMD_READ, 8'h00, 32'h0, 7'h7F);
        queue_word(CMD_FETCH, 8'h00, 32'h0, 7'h00);
        queue_word(CMD_FETCH, 8'h00, 32'h0, 7'h00);
        wait_drained();

        for (int p = 0; p < 5; p++) begin
            apb_write({REG_TERM_VALUE, 2'b00}, {24'h0, vals[p]});
            apb_write({REG_TERM_RUN, 2'b00}, {30'h0, runs[p]});
            case (p % 4)
                0: begin send_idle_pct = 0; stall_pct = 0; end
                1: begin send_idle_pct = 84; stall_pct = 0; end
                2: begin send_idle_pct = 0; stall_pct = 84; end
                default: begin send_idle_pct = 38; stall_pct = 38; end
            endcase
            if (p == 0) hold_go = 1;
            for (int k = 0; k < SLOT_COUNT + 2; k++) queue_message($urandom_range(1, 6));
            queue_random(4);
            if (p == 1) wait (words_to_send.size() == 0 && results_due.size() == 0);
            queue_random(4);
            wait (words_to_send.size() == 0);
            send_idle_pct = 0; stall_pct = 0;
            queue_random(2);
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
